// ===== hdl/lrupr_pkg.sv =====
// shared types and constants for the lru page replacement store
package lrupr_pkg;

  localparam int LRUPR_FRAMES     = 16;
  localparam int LRUPR_PAGE_W     = 16;
  localparam int LRUPR_CFG_W      = 5;
  localparam int LRUPR_FAULT_W    = 32;
  localparam int LRUPR_LIMIT_RST  = 16;
  localparam int LRUPR_IN_DATA_W  = 16;
  localparam int LRUPR_OUT_DATA_W = 56;

  // one entry handed from a cell to the next one down the recency stack
  typedef struct packed {
    logic [LRUPR_PAGE_W-1:0] tag;
    logic                    valid;
  } lrupr_link_t;

  // per-word controls common to every cell
  typedef struct packed {
    logic                    upd;
    logic                    clear;
    logic                    evict;
    logic [LRUPR_PAGE_W-1:0] page;
  } lrupr_ctrl_t;

endpackage

// ===== hdl/lrupr_cell.sv =====
// one position of the recency stack: holds a page tag, compares it and shifts down
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lrupr_ctrl_t             ctrl,
  input  logic [OCC_W-1:0]        occ,
  input  lrupr_link_t             prev,
  input  logic                    found_in,
  output lrupr_link_t             link,
  output logic                    found_out,
  output logic [LRUPR_PAGE_W-1:0] ev_tag
);

  logic [LRUPR_PAGE_W-1:0] tag;
  logic                    valid;
  logic                    eff_valid;
  logic                    is_last;
  logic                    match;

  assign eff_valid = valid & ~ctrl.clear;
  assign is_last   = (occ == OCC_W'(IDX + 1));
  assign match     = eff_valid && (tag == ctrl.page);
  assign found_out = found_in | match;

  // the least recent entry is dropped instead of moving down
  assign link.tag   = tag;
  assign link.valid = eff_valid & ~(ctrl.evict & is_last);
  assign ev_tag     = (ctrl.evict && is_last) ? tag : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.upd && !found_in) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && !found_in) begin
      tag <= prev.tag;
    end
  end

endmodule

// ===== hdl/lru_page_replacement.sv =====
// lru page replacement store: recency stack built from a chain of tag cells
//
//  channel   dir  width  contents
//  s_axis    in   16+1   tdata = page, tuser = start_new
//  m_axis    out  56     tdata = hit, fault_count, evicted_valid, evicted_page
//  cfg       in   5      frames_in_use, written when cfg_we is high
//
// one word per cycle unless the output stalls; a result is registered; the found
// chain ripples through all FRAMES cells as a word is taken and sets the clock.
// reset empties the stack, clears the fault count and sets frames_in_use to 16.
// a stalled result holds in the output register; input is taken while it drains.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES = LRUPR_FRAMES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [LRUPR_IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] page
  input  logic [0:0]                  s_axis_tuser,   // [0] start_new
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] hit, [32:1] fault_count, [33] evicted_valid, [49:34] evicted_page, rest zero
  output logic [LRUPR_OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                        cfg_we,
  input  logic [LRUPR_CFG_W-1:0]      cfg_wdata
);

  localparam int OCC_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (OCC_W > LRUPR_CFG_W) ? OCC_W : LRUPR_CFG_W;

  logic [LRUPR_CFG_W-1:0]   frames_in_use;
  logic [OCC_W-1:0]         occ;
  logic [OCC_W-1:0]         occ_next;
  logic [OCC_W-1:0]         occ_eff;
  logic [LRUPR_FAULT_W-1:0] faults;
  logic [LRUPR_FAULT_W-1:0] faults_eff;
  logic [LRUPR_FAULT_W-1:0] faults_next;
  logic [CMP_W-1:0]         cfg_ext;
  logic [CMP_W-1:0]         limit;
  logic                     accept;
  logic                     hit;

  lrupr_ctrl_t              ctrl;
  lrupr_link_t              links [FRAMES+1];
  logic                     found [FRAMES+1];
  logic [LRUPR_PAGE_W-1:0]  ev_tags [FRAMES];
  logic [LRUPR_PAGE_W-1:0]  ev_page;

  logic                     hit_q;
  logic [LRUPR_FAULT_W-1:0] fault_q;
  logic                     ev_valid_q;
  logic [LRUPR_PAGE_W-1:0]  ev_page_q;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // effective limit: zero acts as one, anything above FRAMES acts as FRAMES
  assign cfg_ext = CMP_W'(frames_in_use);
  always_comb begin
    priority if (cfg_ext == '0) begin
      limit = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      limit = CMP_W'(FRAMES);
    end else begin
      limit = cfg_ext;
    end
  end

  assign occ_eff    = s_axis_tuser[0] ? '0 : occ;
  assign faults_eff = s_axis_tuser[0] ? '0 : faults;

  assign ctrl.upd   = accept;
  assign ctrl.clear = s_axis_tuser[0];
  assign ctrl.page  = s_axis_tdata[LRUPR_PAGE_W-1:0];
  assign ctrl.evict = ~hit && (CMP_W'(occ_eff) >= limit);

  assign links[0].tag   = s_axis_tdata[LRUPR_PAGE_W-1:0];
  assign links[0].valid = 1'b1;
  assign found[0]       = 1'b0;
  assign hit            = found[FRAMES];

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .IDX   (i),
      .OCC_W (OCC_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .occ       (occ_eff),
      .prev      (links[i]),
      .found_in  (found[i]),
      .link      (links[i+1]),
      .found_out (found[i+1]),
      .ev_tag    (ev_tags[i])
    );
  end

  // at most one cell reports an evicted tag
  always_comb begin
    ev_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      ev_page = ev_page | ev_tags[i];
    end
  end

  always_comb begin
    priority if (hit || ctrl.evict) begin
      occ_next = occ_eff;
    end else begin
      occ_next = occ_eff + OCC_W'(1);
    end
  end

  always_comb begin
    if (!hit && faults_eff != '1) begin
      faults_next = faults_eff + LRUPR_FAULT_W'(1);
    end else begin
      faults_next = faults_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= LRUPR_CFG_W'(LRUPR_LIMIT_RST);
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      faults <= '0;
    end else if (accept) begin
      occ    <= occ_next;
      faults <= faults_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_q      <= hit;
      fault_q    <= faults_next;
      ev_valid_q <= ctrl.evict;
      ev_page_q  <= ev_page;
    end
  end

  assign m_axis_tdata = {6'd0, ev_page_q, ev_valid_q, fault_q, hit_q};

  // occupancy never passes the number of cells
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(FRAMES))
    else $error("occupancy above frame count");

  // after any accepted word the stack holds at least one page
  a_occ_nonzero: assert property (@(posedge clk) disable iff (rst)
    accept |=> occ != '0)
    else $error("stack empty after a reference");

  // an eviction only comes with a fault
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ev_valid_q |-> !hit_q && fault_q != '0)
    else $error("eviction reported on a hit");

  // a fault result never carries a zero count
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !hit_q |-> fault_q != '0)
    else $error("fault result with zero count");

endmodule
